@@ rtl/core/msgenc_pkg.sv @@
package msgenc_pkg;

   localparam int unsigned FrameBytes = 9;
   localparam int unsigned CountWidth = 4;

   localparam logic [2:0] MODE_BOOL   = 3'd0;
   localparam logic [2:0] MODE_UINT   = 3'd1;
   localparam logic [2:0] MODE_STRHDR = 3'd2;
   localparam logic [2:0] MODE_ARRHDR = 3'd3;
   localparam logic [2:0] MODE_RAW    = 3'd4;

   localparam logic [7:0] TAG_FALSE  = 8'hc2;
   localparam logic [7:0] TAG_TRUE   = 8'hc3;
   localparam logic [7:0] TAG_UINT8  = 8'hcc;
   localparam logic [7:0] TAG_UINT16 = 8'hcd;
   localparam logic [7:0] TAG_UINT32 = 8'hce;
   localparam logic [7:0] TAG_UINT64 = 8'hcf;
   localparam logic [7:0] TAG_FIXSTR = 8'ha0;
   localparam logic [7:0] TAG_STR8   = 8'hd9;
   localparam logic [7:0] TAG_STR16  = 8'hda;
   localparam logic [7:0] TAG_STR32  = 8'hdb;
   localparam logic [7:0] TAG_FIXARR = 8'h90;
   localparam logic [7:0] TAG_ARR16  = 8'hdc;
   localparam logic [7:0] TAG_ARR32  = 8'hdd;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

   // Encoded frame: first byte in the top bits, count of valid bytes.
   typedef struct packed {
      logic [8*FrameBytes-1:0] bytes;
      logic [CountWidth-1:0]   count;
   } frame_type;

   function automatic frame_type encode(input req_type req);
      frame_type   f;
      logic [31:0] v32;
      f   = '0;
      v32 = req.value[31:0];
      case (req.mode)
         MODE_BOOL: begin
            f.bytes = {((req.value != '0) ? TAG_TRUE : TAG_FALSE), 64'd0};
            f.count = 4'd1;
         end
         MODE_UINT: begin
            if (req.value < 64'd128) begin
               f.bytes = {req.value[7:0], 64'd0};
               f.count = 4'd1;
            end else if (req.value[63:8] == '0) begin
               f.bytes = {TAG_UINT8, req.value[7:0], 56'd0};
               f.count = 4'd2;
            end else if (req.value[63:16] == '0) begin
               f.bytes = {TAG_UINT16, req.value[15:0], 48'd0};
               f.count = 4'd3;
            end else if (req.value[63:32] == '0) begin
               f.bytes = {TAG_UINT32, req.value[31:0], 32'd0};
               f.count = 4'd5;
            end else begin
               f.bytes = {TAG_UINT64, req.value};
               f.count = 4'd9;
            end
         end
         MODE_STRHDR: begin
            if (v32 < 32'd32) begin
               f.bytes = {TAG_FIXSTR | v32[7:0], 64'd0};
               f.count = 4'd1;
            end else if (v32[31:8] == '0) begin
               f.bytes = {TAG_STR8, v32[7:0], 56'd0};
               f.count = 4'd2;
            end else if (v32[31:16] == '0) begin
               f.bytes = {TAG_STR16, v32[15:0], 48'd0};
               f.count = 4'd3;
            end else begin
               f.bytes = {TAG_STR32, v32, 32'd0};
               f.count = 4'd5;
            end
         end
         MODE_ARRHDR: begin
            if (v32 < 32'd16) begin
               f.bytes = {TAG_FIXARR | v32[7:0], 64'd0};
               f.count = 4'd1;
            end else if (v32[31:16] == '0) begin
               f.bytes = {TAG_ARR16, v32[15:0], 48'd0};
               f.count = 4'd3;
            end else begin
               f.bytes = {TAG_ARR32, v32, 32'd0};
               f.count = 4'd5;
            end
         end
         MODE_RAW: begin
            f.bytes = {req.value[7:0], 64'd0};
            f.count = 4'd1;
         end
         default: begin
            // unused modes produce no bytes
            f = '0;
         end
      endcase
      return f;
   endfunction

endpackage

@@ rtl/core/msgpack_value_encoder_unit.sv @@
// The first byte of an item passes the frame shifter, then the result register, before rsp_valid.
// Throughput: one byte per cycle while rsp_ready is high; an item has 1 to 9 bytes,
// drained from the frame shifter through the single byte-wide rsp port.
// The next req transfer overlaps the cycle that drains the previous frame's last byte.
// Reset (synchronous, active high) empties the shifter and the rsp register;
// no other state is kept.
module msgpack_value_encoder_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  msgenc_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output msgenc_pkg::rsp_type rsp_payload
);
   import msgenc_pkg::*;

   // Frame shifter: remaining bytes of the current item, next byte on top.
   logic [8*FrameBytes-1:0] frame_ff, frame_in;
   logic [CountWidth-1:0]   cnt_ff, cnt_in;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   frame_type enc;
   logic      req_xfer;
   logic      advance;

   assign enc = encode(req_payload);

   // Move one byte into the result register when it is empty or being drained.
   assign advance   = (cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);

   // Accept a new item once the shifter is empty or about to be.
   assign req_ready = (cnt_ff == '0) || ((cnt_ff == CountWidth'(1)) && advance);
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      frame_in     = frame_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_byte = frame_ff[8*FrameBytes-1 -: 8];
         rsp_in.last     = (cnt_ff == CountWidth'(1));
         frame_in        = {frame_ff[8*FrameBytes-9:0], 8'd0};
         cnt_in          = cnt_ff - CountWidth'(1);
      end

      // Load wins: the old frame is empty by now.
      if (req_xfer) begin
         frame_in = enc.bytes;
         cnt_in   = enc.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff <= frame_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/core/msgenc_checker.sv @@
module msgenc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input msgenc_pkg::req_type req_payload,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input msgenc_pkg::rsp_type rsp_payload
);
   import msgenc_pkg::*;

   // Stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp dropped or changed while stalled");

   // After a non-last byte transfer, the next byte follows at once.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last |=> rsp_valid)
      else $error("gap inside an encoded item");

   // No new item while a stalled byte is not the last of its item.
   a_no_overtake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !rsp_payload.last |-> !req_ready)
      else $error("req taken before current item drained");

   // Reset leaves the block empty and ready.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind msgpack_value_encoder_unit msgenc_checker u_msgenc_checker (.*);
